// ===== hw/rtl/pngchk_pkg.sv =====
// Shared types, constants and functions for the PNG header check unit.
// Holds the status codes, the fixed header bytes and the bytewise CRC-32 step.
// Depends on nothing.
package pngchk_pkg;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_BAD_SIG  = 3'd2,
        ST_BAD_LEN  = 3'd3,
        ST_BAD_NAME = 3'd4,
        ST_BAD_CRC  = 3'd5
    } t_status;

    // Byte position counter and the landmarks in the 33-byte header.
    localparam int POS_W = 6;
    typedef logic [POS_W-1:0] t_pos;

    localparam t_pos POS_SIG_END  = t_pos'(8);   // first byte after the signature
    localparam t_pos POS_LEN_LAST = t_pos'(11);
    localparam t_pos POS_NAME     = t_pos'(12);
    localparam t_pos POS_DATA     = t_pos'(16);
    localparam t_pos POS_WIDTH    = t_pos'(19);
    localparam t_pos POS_HEIGHT   = t_pos'(23);
    localparam t_pos POS_DEPTH    = t_pos'(24);
    localparam t_pos POS_COLOUR   = t_pos'(25);
    localparam t_pos POS_CRC      = t_pos'(29);
    localparam t_pos POS_LAST_HDR = t_pos'(32);
    localparam t_pos POS_DONE     = t_pos'(33);

    localparam logic [31:0] IHDR_LENGTH = 32'd13;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_PRESET  = 32'hFFFF_FFFF;

    // Output item layout, lowest bits first.
    localparam int STATUS_W = 3;
    localparam int DIM_W    = 32;
    localparam int BYTE_W   = 8;
    localparam int OUT_BITS = STATUS_W + 2 * DIM_W + 2 * BYTE_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Expected signature byte at positions 0 to 7.
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'd137;
            3'd1:    b = 8'd80;
            3'd2:    b = 8'd78;
            3'd3:    b = 8'd71;
            3'd4:    b = 8'd13;
            3'd5:    b = 8'd10;
            3'd6:    b = 8'd26;
            default: b = 8'd10;
        endcase
        return b;
    endfunction

    // Expected chunk name byte, "IHDR".
    function automatic logic [7:0] name_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'd73;
            2'd1:    b = 8'd72;
            2'd2:    b = 8'd68;
            default: b = 8'd82;
        endcase
        return b;
    endfunction

    // One byte of the reflected CRC-32, eight bit steps.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/png_header_check_unit.sv =====
// Top level of the PNG header check unit: byte stream in, one header result out.
// Uses pngchk_pkg for status codes, header constants and the CRC-32 step.
//
// Channel | Direction | Contents
// s       | in        | tdata[7:0] data_byte, tlast last_byte
// m       | out       | tdata: status, image_width, image_height, pixel_depth, colour_mode
//
// Each byte is taken when accepted; a new byte can follow in the next cycle unless a stalled result holds input.
// The CRC update (eight bit steps of the reflected CRC-32) sets the path length.
// The result sits in an output register; input is taken whenever that register
// is empty or is being emptied in the same cycle, so only a stalled result stalls input.
// Reset is synchronous and active low; the next byte after a last mark starts a new body.
module png_header_check_unit
    import pngchk_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [7:0]        i_s_tdata,    // [7:0] data_byte
    input  logic              i_s_tlast,    // last_byte
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // [2:0] status, [34:3] image_width, [66:35] image_height,
    // [74:67] pixel_depth, [82:75] colour_mode, [87:83] zero
    output logic [OUT_W-1:0]  o_m_tdata
);

    // Parsing state.
    t_pos        r_pos,       n_pos;
    logic [31:0] r_crc,       n_crc;
    t_status     r_err,       n_err;
    logic [31:0] r_shift,     n_shift;
    logic [31:0] r_width,     n_width;
    logic [31:0] r_height,    n_height;
    logic [7:0]  r_depth,     n_depth;
    logic [7:0]  r_colour,    n_colour;

    // Output register.
    logic             r_out_valid, n_out_valid;
    logic [OUT_W-1:0] r_out_data,  n_out_data;

    logic    accept;
    logic    res_valid;
    t_status res_status;
    logic    hdr_byte;
    t_status err_step;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Per-byte header checks and field capture.
    always_comb begin
        n_pos    = r_pos;
        n_crc    = r_crc;
        n_err    = r_err;
        n_shift  = r_shift;
        n_width  = r_width;
        n_height = r_height;
        n_depth  = r_depth;
        n_colour = r_colour;
        err_step = ST_OK;
        res_valid  = 1'b0;
        res_status = ST_OK;
        hdr_byte   = (r_pos < POS_DONE);

        if (hdr_byte) begin
            n_shift = {r_shift[23:0], i_s_tdata};
            if (r_pos < POS_SIG_END) begin
                if (i_s_tdata != sig_byte(r_pos[2:0])) begin
                    err_step = ST_BAD_SIG;
                end
            end else if (r_pos < POS_NAME) begin
                if (r_pos == POS_LEN_LAST && n_shift != IHDR_LENGTH) begin
                    err_step = ST_BAD_LEN;
                end
            end else if (r_pos < POS_CRC) begin
                n_crc = crc_byte(r_crc, i_s_tdata);
                if (r_pos < POS_DATA) begin
                    if (i_s_tdata != name_byte(r_pos[1:0])) begin
                        err_step = ST_BAD_NAME;
                    end
                end
                if (r_pos == POS_WIDTH) begin
                    n_width = n_shift;
                end
                if (r_pos == POS_HEIGHT) begin
                    n_height = n_shift;
                end
                if (r_pos == POS_DEPTH) begin
                    n_depth = i_s_tdata;
                end
                if (r_pos == POS_COLOUR) begin
                    n_colour = i_s_tdata;
                end
            end else if (r_pos == POS_LAST_HDR) begin
                if (n_shift != ~r_crc) begin
                    err_step = ST_BAD_CRC;
                end
            end

            // Keep only the earliest error.
            if (r_err == ST_OK) begin
                n_err = err_step;
            end

            if (r_pos == POS_LAST_HDR) begin
                res_valid  = 1'b1;
                res_status = n_err;
                n_pos      = POS_DONE;
            end else if (i_s_tlast) begin
                res_valid  = 1'b1;
                res_status = ST_SHORT;
            end else begin
                n_pos = r_pos + t_pos'(1);
            end
        end

        // A last mark always returns the parser to its reset state.
        if (i_s_tlast) begin
            n_pos = '0;
            n_crc = CRC_PRESET;
            n_err = ST_OK;
        end
    end

    // Output register load and drain.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
        if (accept && res_valid) begin
            n_out_valid = 1'b1;
            n_out_data  = '0;
            n_out_data[STATUS_W-1:0] = res_status;
            if (res_status == ST_OK) begin
                n_out_data[OUT_BITS-1:STATUS_W] = {n_colour, n_depth, n_height, n_width};
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_crc       <= CRC_PRESET;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_pos <= n_pos;
                r_crc <= n_crc;
                r_err <= n_err;
            end
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_shift  <= n_shift;
            r_width  <= n_width;
            r_height <= n_height;
            r_depth  <= n_depth;
            r_colour <= n_colour;
        end
        r_out_data <= n_out_data;
    end

    // Checks.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_DONE)
        else $error("byte position beyond header end");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_s_tlast |=> r_pos == '0 && r_crc == CRC_PRESET && r_err == ST_OK)
        else $error("parser not cleared after last byte");

    a_error_clears_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data[STATUS_W-1:0] != ST_OK |->
            r_out_data[OUT_BITS-1:STATUS_W] == '0)
        else $error("header fields given with an error status");

    a_error_needs_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err != ST_OK |-> r_pos != '0)
        else $error("error held at the start of a body");

endmodule
